FILE: rtl/cnfc_pkg.sv
// Package for the class number form counter.
// Shared types and constants; no dependencies.
`timescale 1ns / 1ps
package cnfc_pkg;
	localparam int DISC_BITS_DEF = 16;
	localparam int COUNT_W       = 10;
	localparam int TDATA_OUT_W   = 16;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	typedef enum logic [3:0] {
		BK_IDLE, BK_SQRT, BK_PAIR, BK_DIV, BK_CHK, BK_GCD1, BK_GCD2, BK_NEXT, BK_DONE
	} bk_state_t;
endpackage

FILE: rtl/cnfc_front.sv
// Front end: accepts transactions, masks d and queues it (two entries).
// Depends on cnfc_pkg.
`timescale 1ns / 1ps
module cnfc_front #(
	parameter int DISC_BITS = cnfc_pkg::DISC_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [((DISC_BITS+7)/8)*8-1:0]   in_data,
	output logic                             q_valid,
	input  logic                             q_ready,
	output logic [DISC_BITS-1:0]             q_d
);
	logic [DISC_BITS-1:0] mem_q [2];
	logic wr_q, rd_q;
	logic [1:0] cnt_q;

	assign in_ready = (cnt_q != 2'd2);
	assign q_valid  = (cnt_q != 2'd0);
	assign q_d      = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) mem_q[wr_q] <= in_data[DISC_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0; rd_q <= 1'b0; cnt_q <= 2'd0;
		end else begin
			if (in_valid && in_ready) wr_q <= ~wr_q;
			if (q_valid && q_ready) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, in_valid && in_ready} - {1'b0, q_valid && q_ready};
		end
	end

	a_cnt: assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("queue count out of range");
endmodule

FILE: rtl/cnfc_back.sv
// Back end: root search for the A bound, enumerates (A,B), bit-serial divide,
// Euclid gcd, counting. Depends on cnfc_pkg.
`timescale 1ns / 1ps
module cnfc_back #(
	parameter int DISC_BITS = cnfc_pkg::DISC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_valid,
	output logic                         q_ready,
	input  logic [DISC_BITS-1:0]         q_d,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [cnfc_pkg::COUNT_W-1:0] out_count
);
	localparam int AW  = DISC_BITS/2 + 2;     // width of A and |B|
	localparam int SW  = 2*AW + 2;            // width of 3*root^2
	localparam int NW2 = (2*AW > DISC_BITS ? 2*AW : DISC_BITS) + 1;
	localparam int CW  = $clog2(NW2 + 1);

	cnfc_pkg::bk_state_t st_q, st_n;
	logic [DISC_BITS-1:0] d_q;
	logic [AW-1:0] a_q, maxa_q, mag_q;
	logic neg_q;
	logic [NW2-1:0] num_q, rem_q, quo_q;
	logic [AW+1:0] den_q;
	logic [CW-1:0] cnt_q;
	logic [NW2-1:0] gx_q, gy_q;
	logic [cnfc_pkg::COUNT_W-1:0] count_q;
	logic [NW2:0] trial;
	logic [NW2-1:0] a_ext, mag_ext, den_ext;
	logic [NW2-1:0] gmod;
	logic [AW-1:0] cand;
	logic [2*AW-1:0] cand_sq;
	logic [SW-1:0] cand_sq3;
	logic root_fits, quo_bit, skip_pair, last_pair;

	assign q_ready = (st_q == cnfc_pkg::BK_IDLE);
	assign out_valid = (st_q == cnfc_pkg::BK_DONE);
	assign out_count = count_q;
	assign a_ext   = NW2'(a_q);
	assign mag_ext = NW2'(mag_q);
	assign den_ext = NW2'(den_q);
	assign trial   = {rem_q, num_q[NW2-1]};
	assign quo_bit = (trial >= {1'b0, den_ext});
	assign gmod    = (gx_q >= gy_q) ? gx_q - gy_q : gx_q;

	// isqrt(floor(d/3)) is the largest r with 3*r^2 <= d; set one bit per cycle
	assign cand      = quo_q[AW-1:0] | (AW'(1) << (cnt_q - CW'(1)));
	assign cand_sq   = (2*AW)'(cand * cand);
	assign cand_sq3  = {1'b0, cand_sq, 1'b0} + {2'b00, cand_sq};
	assign root_fits = (cand_sq3 <= SW'(d_q));

	// num_q holds C after the divide
	assign skip_pair = rem_q != '0 || a_ext > num_q ||
	                   (neg_q && (mag_ext == a_ext || a_ext == num_q));
	assign last_pair = !neg_q && mag_q == a_q && a_q == maxa_q;

	always_comb begin
		st_n = st_q;
		unique case (st_q)
			cnfc_pkg::BK_IDLE: if (q_valid) st_n = cnfc_pkg::BK_SQRT;
			cnfc_pkg::BK_SQRT: if (cnt_q == '0) st_n = cnfc_pkg::BK_PAIR;
			cnfc_pkg::BK_PAIR: st_n = cnfc_pkg::BK_DIV;
			cnfc_pkg::BK_DIV:  if (cnt_q == CW'(1)) st_n = cnfc_pkg::BK_CHK;
			cnfc_pkg::BK_CHK:  st_n = skip_pair ? cnfc_pkg::BK_NEXT : cnfc_pkg::BK_GCD1;
			cnfc_pkg::BK_GCD1: if (gy_q == '0) st_n = cnfc_pkg::BK_GCD2;
			cnfc_pkg::BK_GCD2: if (gy_q == '0) st_n = cnfc_pkg::BK_NEXT;
			cnfc_pkg::BK_NEXT: st_n = last_pair ? cnfc_pkg::BK_DONE : cnfc_pkg::BK_PAIR;
			cnfc_pkg::BK_DONE: if (out_ready) st_n = cnfc_pkg::BK_IDLE;
			default: st_n = cnfc_pkg::BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= cnfc_pkg::BK_IDLE;
			count_q <= '0;
			d_q <= '0;
			a_q <= '0;
			maxa_q <= '0;
			mag_q <= '0;
			neg_q <= 1'b0;
			num_q <= '0;
			rem_q <= '0;
			quo_q <= '0;
			den_q <= '0;
			cnt_q <= '0;
			gx_q <= '0;
			gy_q <= '0;
		end else begin
			st_q <= st_n;
			case (st_q)
				cnfc_pkg::BK_IDLE: begin
					d_q <= q_d;
					count_q <= '0;
					quo_q <= '0;
					cnt_q <= CW'(AW);
				end
				cnfc_pkg::BK_SQRT: begin
					if (cnt_q != '0) begin
						// keep bit cnt_q-1 of the root when 3*cand^2 still fits under d
						if (root_fits) quo_q <= NW2'(cand);
						cnt_q <= cnt_q - 1'b1;
					end else begin
						maxa_q <= quo_q[AW-1:0] + AW'(2);
						a_q <= AW'(1);
						mag_q <= AW'(1);
						neg_q <= 1'b1;
					end
				end
				cnfc_pkg::BK_PAIR: begin
					num_q <= NW2'(mag_ext[AW-1:0] * mag_ext[AW-1:0]) + NW2'(d_q);
					den_q <= {a_q, 2'b00};
					rem_q <= '0;
					cnt_q <= CW'(NW2);
				end
				cnfc_pkg::BK_DIV: begin
					if (cnt_q != '0) begin
						if (quo_bit) rem_q <= NW2'(trial - {1'b0, den_ext});
						else rem_q <= trial[NW2-1:0];
						num_q <= {num_q[NW2-2:0], quo_bit};
						cnt_q <= cnt_q - 1'b1;
					end
				end
				cnfc_pkg::BK_CHK: begin
					if (!skip_pair) begin
						gx_q <= a_ext; gy_q <= mag_ext; quo_q <= num_q;
					end
				end
				cnfc_pkg::BK_GCD1: begin
					// subtractive Euclid step per cycle
					if (gy_q == '0) gy_q <= quo_q;
					else if (gx_q >= gy_q) gx_q <= gx_q - gy_q;
					else begin gx_q <= gy_q; gy_q <= gx_q; end
				end
				cnfc_pkg::BK_GCD2: begin
					if (gy_q == '0) begin
						if (gx_q == NW2'(1) && count_q != cnfc_pkg::COUNT_MAX)
							count_q <= count_q + 1'b1;
					end else if (gx_q >= gy_q) gx_q <= gmod;
					else begin gx_q <= gy_q; gy_q <= gx_q; end
				end
				cnfc_pkg::BK_NEXT: begin
					// B runs -A..A as (neg,mag): mag A..1 negative, then 0..A
					if (neg_q) begin
						if (mag_q == AW'(1)) begin mag_q <= '0; neg_q <= 1'b0; end
						else mag_q <= mag_q - 1'b1;
					end else if (mag_q != a_q) mag_q <= mag_q + 1'b1;
					else if (a_q != maxa_q) begin
						a_q <= a_q + 1'b1; mag_q <= a_q + 1'b1; neg_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_count)) else $error("result lost");
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		q_valid && q_ready |=> count_q == '0) else $error("count not cleared");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_ready && out_valid)) else $error("overlap");
endmodule

FILE: rtl/class_number_form_counter.sv
// Class number form counter top level: d in, count of primitive reduced forms out.
// Depends on cnfc_pkg, cnfc_front, cnfc_back.
`timescale 1ns / 1ps
// Counts the primitive reduced binary quadratic forms of discriminant -d.
// One transaction in gives one result out. The front queues up to two
// values of d; the back unit handles one d at a time. It first finds
// isqrt(d/3) by a bit search, then visits every pair (A,B) with A up to
// isqrt(d/3)+2 and |B| <= A, about d/3 pairs. Each pair passes a setup
// state, a restoring divide of |B|^2+d by 4A at one bit per cycle, a check
// state and an advance state. Pairs that pass the divisibility and
// reduction checks add a subtractive gcd. The input stalls once two values
// of d wait in the queue. The count saturates at 1023.
module class_number_form_counter #(
	parameter int DISC_BITS = cnfc_pkg::DISC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [((DISC_BITS+7)/8)*8-1:0] s_axis_tdata,  // [DISC_BITS-1:0] abs_disc
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [cnfc_pkg::TDATA_OUT_W-1:0] m_axis_tdata   // [9:0] class_count, rest zero
);
	logic q_valid, q_ready;
	logic [DISC_BITS-1:0] q_d;
	logic [cnfc_pkg::COUNT_W-1:0] cnt;

	// accept and queue
	cnfc_front #(.DISC_BITS(DISC_BITS)) u_front (
		.clk, .arst_n, .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_data(s_axis_tdata), .q_valid, .q_ready, .q_d
	);

	// enumerate and count
	cnfc_back #(.DISC_BITS(DISC_BITS)) u_back (
		.clk, .arst_n, .q_valid, .q_ready, .q_d,
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_count(cnt)
	);

	assign m_axis_tdata = {{(cnfc_pkg::TDATA_OUT_W - cnfc_pkg::COUNT_W){1'b0}}, cnt};
endmodule
